// File: rtl/bts_pkg.sv
`default_nettype none

package bts_pkg;

    // Default sizes of the texel store and coordinate fraction
    localparam int MAX_WIDTH_DEF  = 256;
    localparam int MAX_HEIGHT_DEF = 256;
    localparam int FRAC_BITS_DEF  = 16;

    // Fixed field widths
    localparam int SIZE_W  = 9;
    localparam int COORD_W = 18;
    localparam int TEXEL_W = 32;
    localparam int POS_W   = 8;
    localparam int CH_W    = 8;
    localparam int NUM_CH  = 4;

    // Stream packing
    localparam int S_TDATA_W = 88;
    localparam int M_TDATA_W = 32;

    // Register indexes
    localparam logic [0:0] REG_TEX_WIDTH  = 1'b0;
    localparam logic [0:0] REG_TEX_HEIGHT = 1'b1;

    // Request kinds
    localparam logic OP_WRITE  = 1'b0;
    localparam logic OP_SAMPLE = 1'b1;

    // Microprogram step addresses
    localparam int STEP_W = 4;
    localparam logic [STEP_W-1:0] STEP_IDLE = 4'd0;
    localparam logic [STEP_W-1:0] STEP_MAP  = 4'd1;
    localparam logic [STEP_W-1:0] STEP_CHK  = 4'd2;
    localparam logic [STEP_W-1:0] STEP_RD00 = 4'd3;
    localparam logic [STEP_W-1:0] STEP_RD10 = 4'd4;
    localparam logic [STEP_W-1:0] STEP_RD01 = 4'd5;
    localparam logic [STEP_W-1:0] STEP_RD11 = 4'd6;
    localparam logic [STEP_W-1:0] STEP_MIX1 = 4'd7;
    localparam logic [STEP_W-1:0] STEP_MIX2 = 4'd8;
    localparam logic [STEP_W-1:0] STEP_MIX3 = 4'd9;
    localparam logic [STEP_W-1:0] STEP_FIN  = 4'd10;

    typedef enum logic [2:0] {
        RD_NONE,
        RD_00,
        RD_10,
        RD_01,
        RD_11
    } corner_t;

    typedef enum logic [2:0] {
        MAC_NONE,
        MAC_H_LOAD,   // h  = c * (1-s)
        MAC_H_ADD,    // h += c * s
        MAC_H_SWAP,   // a0 = h, h = c * (1-s)
        MAC_F_LOAD,   // f  = a0 * (1-t)
        MAC_F_ADD     // f += h * t
    } mac_t;

    typedef enum logic [1:0] {
        SEQ_START,    // wait for a sample request
        SEQ_NEXT,     // fall through
        SEQ_JMP_OUT,  // jump to target when the coordinate is outside
        SEQ_FIN       // hold until the result register is free
    } seq_t;

    typedef struct packed {
        logic              map_en;
        logic              chk_en;
        corner_t           rd;
        mac_t              mac;
        seq_t              seq;
        logic [STEP_W-1:0] tgt;
    } ctrl_t;

    function automatic ctrl_t uc_rom(logic [STEP_W-1:0] step);
        ctrl_t cw;
        cw = '{map_en: 1'b0, chk_en: 1'b0, rd: RD_NONE, mac: MAC_NONE,
               seq: SEQ_NEXT, tgt: STEP_IDLE};
        unique case (step)
            STEP_IDLE: cw.seq = SEQ_START;
            STEP_MAP:  cw.map_en = 1'b1;
            STEP_CHK: begin
                cw.chk_en = 1'b1;
                cw.seq    = SEQ_JMP_OUT;
                cw.tgt    = STEP_FIN;
            end
            STEP_RD00: cw.rd = RD_00;
            STEP_RD10: begin
                cw.rd  = RD_10;
                cw.mac = MAC_H_LOAD;
            end
            STEP_RD01: begin
                cw.rd  = RD_01;
                cw.mac = MAC_H_ADD;
            end
            STEP_RD11: begin
                cw.rd  = RD_11;
                cw.mac = MAC_H_SWAP;
            end
            STEP_MIX1: cw.mac = MAC_H_ADD;
            STEP_MIX2: cw.mac = MAC_F_LOAD;
            STEP_MIX3: cw.mac = MAC_F_ADD;
            STEP_FIN:  cw.seq = SEQ_FIN;
            default:   cw.seq = SEQ_FIN;
        endcase
        return cw;
    endfunction

    // Register write value: zero reads as one, above the store size clamps
    function automatic logic [SIZE_W-1:0] clamp_size(logic [SIZE_W-1:0] v,
                                                     int unsigned maxv);
        logic [SIZE_W-1:0] r;
        if (v == '0) begin
            r = SIZE_W'(1);
        end else if (32'(v) > maxv) begin
            r = SIZE_W'(maxv);
        end else begin
            r = v;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// File: rtl/bilinear_texture_sampler_unit.sv
`default_nettype none
// Write request: stored at the accepting edge, no result; one write per cycle while idle.
// Sample request: steps map, check, four texel reads from the single-port texel RAM,
// the blend steps of the microprogram and the final step, which loads the result;
// an outside coordinate jumps from check to the final step. No new request until idle.
// A result not yet taken holds the sequencer in its final step until m_tready.
// Reset (aresetn low, synchronous): sequencer idle, no result pending, sizes
// back to full store size. The texel RAM is not cleared.

module bilinear_texture_sampler_unit #(
    parameter int MAX_WIDTH  = bts_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = bts_pkg::MAX_HEIGHT_DEF,
    parameter int FRAC_BITS  = bts_pkg::FRAC_BITS_DEF
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    // configuration write port
    input  wire logic                           cfg_we,
    input  wire logic [0:0]                     cfg_addr,
    input  wire logic [bts_pkg::SIZE_W-1:0]     cfg_wdata,
    // request stream
    input  wire logic                           s_tvalid,
    output      logic                           s_tready,
    // texel_x[7:0], texel_y[15:8], texel_rgba[47:16], coord_u[65:48],
    // coord_v[83:66], zero pad [87:84]
    input  wire logic [bts_pkg::S_TDATA_W-1:0]  s_tdata,
    // op
    input  wire logic                           s_tuser,
    // result stream
    output      logic                           m_tvalid,
    input  wire logic                           m_tready,
    // red[7:0], green[15:8], blue[23:16], alpha[31:24]
    output      logic [bts_pkg::M_TDATA_W-1:0]  m_tdata,
    // outside
    output      logic                           m_tuser
);

    import bts_pkg::*;

    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = $clog2(DEPTH);
    // mapped coordinate: 18b x 10b product plus half, with room for the
    // integer part to carry at least 10 bits above the fraction
    localparam int PW    = (FRAC_BITS + 10 > 28) ? FRAC_BITS + 10 : 28;
    localparam int IW    = PW - FRAC_BITS;
    localparam int WW    = FRAC_BITS + 1;         // weight, 0..1.0
    localparam int HW    = FRAC_BITS + CH_W;      // horizontal blend
    localparam int FW    = 2 * FRAC_BITS + CH_W;  // full blend
    localparam int HPW   = CH_W + WW;
    localparam int FPW   = HW + WW;

    localparam logic [PW-1:0] HALF_U   = PW'(1) << (FRAC_BITS - 1);
    localparam logic [WW-1:0] ONE_W    = WW'(1) << FRAC_BITS;
    localparam logic [FW-1:0] HALF_OUT = FW'(1) << (2 * FRAC_BITS - 1);

    // ---------------------------------------------------------------
    // Configuration
    // ---------------------------------------------------------------
    logic [SIZE_W-1:0] tex_width_reg, tex_height_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tex_width_reg  <= clamp_size(SIZE_W'(256), MAX_WIDTH);
            tex_height_reg <= clamp_size(SIZE_W'(256), MAX_HEIGHT);
        end else if (cfg_we) begin
            unique case (cfg_addr)
                REG_TEX_WIDTH:  tex_width_reg  <= clamp_size(cfg_wdata, MAX_WIDTH);
                REG_TEX_HEIGHT: tex_height_reg <= clamp_size(cfg_wdata, MAX_HEIGHT);
                default: ;
            endcase
        end
    end

    // ---------------------------------------------------------------
    // Request unpack
    // ---------------------------------------------------------------
    logic [POS_W-1:0]          in_x, in_y;
    logic [TEXEL_W-1:0]        in_rgba;
    logic signed [COORD_W-1:0] in_u, in_v;

    assign in_x    = s_tdata[7:0];
    assign in_y    = s_tdata[15:8];
    assign in_rgba = s_tdata[47:16];
    assign in_u    = $signed(s_tdata[65:48]);
    assign in_v    = $signed(s_tdata[83:66]);

    // ---------------------------------------------------------------
    // Sequencer
    // ---------------------------------------------------------------
    logic [STEP_W-1:0] step_reg, step_next;
    ctrl_t             cw;
    logic              s_accept;
    logic              out_free;
    logic              out_now;      // outside test, valid in the check step
    logic              m_tvalid_reg, m_tvalid_next;

    assign cw       = uc_rom(step_reg);
    assign s_tready = (cw.seq == SEQ_START);
    assign s_accept = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;

    always_comb begin
        step_next = step_reg;
        unique case (cw.seq)
            SEQ_START: begin
                if (s_accept && (s_tuser == OP_SAMPLE)) begin
                    step_next = step_reg + STEP_W'(1);
                end
            end
            SEQ_NEXT:    step_next = step_reg + STEP_W'(1);
            SEQ_JMP_OUT: step_next = out_now ? cw.tgt : step_reg + STEP_W'(1);
            SEQ_FIN: begin
                if (out_free) begin
                    step_next = STEP_IDLE;
                end
            end
            default: step_next = STEP_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg <= STEP_IDLE;
        end else begin
            step_reg <= step_next;
        end
    end

    // ---------------------------------------------------------------
    // Coordinate mapping and range check
    // ---------------------------------------------------------------
    logic signed [COORD_W-1:0] cu_reg, cv_reg;
    logic signed [PW-1:0]      pu_reg, pv_reg;
    logic signed [PW-1:0]      pu_next, pv_next;
    logic [SIZE_W-1:0]         wm1, hm1;

    assign wm1 = tex_width_reg - SIZE_W'(1);
    assign hm1 = tex_height_reg - SIZE_W'(1);
    assign pu_next = PW'(cu_reg) * PW'($signed({1'b0, wm1})) + $signed(HALF_U);
    assign pv_next = PW'(cv_reg) * PW'($signed({1'b0, hm1})) + $signed(HALF_U);

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            cu_reg <= in_u;
            cv_reg <= in_v;
        end
        if (cw.map_en) begin
            pu_reg <= pu_next;
            pv_reg <= pv_next;
        end
    end

    logic [IW-1:0]        iu, iv;
    logic [SIZE_W-1:0]    u0_c, v0_c;
    logic [SIZE_W:0]      u0p1, v0p1;

    assign iu      = pu_reg[PW-1:FRAC_BITS];
    assign iv      = pv_reg[PW-1:FRAC_BITS];
    assign out_now = pu_reg[PW-1] || pv_reg[PW-1]
                  || (iu >= IW'(tex_width_reg)) || (iv >= IW'(tex_height_reg));
    assign u0_c    = pu_reg[FRAC_BITS+SIZE_W-1:FRAC_BITS];
    assign v0_c    = pv_reg[FRAC_BITS+SIZE_W-1:FRAC_BITS];
    assign u0p1    = {1'b0, u0_c} + (SIZE_W+1)'(1);
    assign v0p1    = {1'b0, v0_c} + (SIZE_W+1)'(1);

    logic [SIZE_W-1:0]    u0_reg, v0_reg, u1_reg, v1_reg;
    logic [WW-1:0]        s_reg, sn_reg, t_reg, tn_reg;
    logic                 outside_reg;

    always_ff @(posedge aclk) begin
        if (cw.chk_en) begin
            outside_reg <= out_now;
            u0_reg      <= u0_c;
            v0_reg      <= v0_c;
            // second index clamps at the last column / row
            u1_reg      <= (u0p1 < {1'b0, tex_width_reg})  ? u0p1[SIZE_W-1:0] : wm1;
            v1_reg      <= (v0p1 < {1'b0, tex_height_reg}) ? v0p1[SIZE_W-1:0] : hm1;
            s_reg       <= {1'b0, pu_reg[FRAC_BITS-1:0]};
            t_reg       <= {1'b0, pv_reg[FRAC_BITS-1:0]};
            sn_reg      <= ONE_W - {1'b0, pu_reg[FRAC_BITS-1:0]};
            tn_reg      <= ONE_W - {1'b0, pv_reg[FRAC_BITS-1:0]};
        end
    end

    // ---------------------------------------------------------------
    // Texel RAM, single port: write on accept, else microprogram read
    // ---------------------------------------------------------------
    logic [TEXEL_W-1:0] mem [DEPTH];
    logic [TEXEL_W-1:0] rdata_reg;
    logic [SIZE_W-1:0]  rd_col, rd_row;
    logic [AW-1:0]      rd_addr, wr_addr;
    logic               wr_en;

    always_comb begin
        rd_col = u0_reg;
        rd_row = v0_reg;
        unique case (cw.rd)
            RD_10: begin rd_col = u1_reg; rd_row = v0_reg; end
            RD_01: begin rd_col = u0_reg; rd_row = v1_reg; end
            RD_11: begin rd_col = u1_reg; rd_row = v1_reg; end
            default: ;
        endcase
    end

    assign rd_addr = AW'(32'(rd_row) * 32'(MAX_WIDTH) + 32'(rd_col));
    assign wr_addr = AW'(32'(in_y) * 32'(MAX_WIDTH) + 32'(in_x));
    assign wr_en   = s_accept && (s_tuser == OP_WRITE)
                  && (32'(in_x) < 32'(MAX_WIDTH)) && (32'(in_y) < 32'(MAX_HEIGHT));

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= in_rgba;
        end else if (cw.rd != RD_NONE) begin
            rdata_reg <= mem[rd_addr];
        end
    end

    // ---------------------------------------------------------------
    // Blend lanes, one per channel (lane 0 = red from texel bits 31:24)
    // blend = (lerp_s(row0) * (1-t) + lerp_s(row1) * t + half) >> 2F
    // ---------------------------------------------------------------
    logic [CH_W-1:0] chan [NUM_CH];

    for (genvar i = 0; i < NUM_CH; i++) begin : g_lane
        logic [CH_W-1:0] c;
        logic [HW-1:0]   h_reg, a0_reg;
        logic [FW-1:0]   f_reg;
        logic [HPW-1:0]  hprod;
        logic [FPW-1:0]  fprod;
        logic [WW-1:0]   hw_sel, fw_sel;
        logic [HW-1:0]   fa_sel;
        logic [FW-1:0]   rnd;

        assign c      = rdata_reg[TEXEL_W-1-CH_W*i -: CH_W];
        assign hw_sel = (cw.mac == MAC_H_ADD) ? s_reg : sn_reg;
        assign fa_sel = (cw.mac == MAC_F_LOAD) ? a0_reg : h_reg;
        assign fw_sel = (cw.mac == MAC_F_LOAD) ? tn_reg : t_reg;
        assign hprod  = HPW'(c) * HPW'(hw_sel);
        assign fprod  = FPW'(fa_sel) * FPW'(fw_sel);

        always_ff @(posedge aclk) begin
            unique case (cw.mac)
                MAC_H_LOAD: h_reg <= HW'(hprod);
                MAC_H_ADD:  h_reg <= h_reg + HW'(hprod);
                MAC_H_SWAP: begin
                    a0_reg <= h_reg;
                    h_reg  <= HW'(hprod);
                end
                MAC_F_LOAD: f_reg <= FW'(fprod);
                MAC_F_ADD:  f_reg <= f_reg + FW'(fprod);
                default: ;
            endcase
        end

        assign rnd     = f_reg + HALF_OUT;
        assign chan[i] = rnd[FW-1:2*FRAC_BITS];
    end

    // ---------------------------------------------------------------
    // Result register
    // ---------------------------------------------------------------
    logic [M_TDATA_W-1:0] m_data_reg;
    logic                 m_out_reg;
    logic                 res_load;

    assign res_load = (cw.seq == SEQ_FIN) && out_free;

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (res_load) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_load) begin
            m_out_reg  <= outside_reg;
            m_data_reg <= outside_reg ? '0 : {chan[3], chan[2], chan[1], chan[0]};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_out_reg;

`ifndef SYNTHESIS
    a_sample_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept && (s_tuser == OP_SAMPLE) |=> step_reg == STEP_MAP)
        else $error("sample request did not start the microprogram");

    a_step_range: assert property (@(posedge aclk) disable iff (!aresetn)
        step_reg <= STEP_FIN)
        else $error("step counter beyond last step");

    a_result_from_fin: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid_reg) |-> $past(step_reg) == STEP_FIN)
        else $error("result raised outside the final step");

    a_outside_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tdata == '0)
        else $error("outside result carries nonzero color");

    a_no_write_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        wr_en |-> step_reg == STEP_IDLE)
        else $error("texel write while a sample is in progress");
`endif

endmodule

`default_nettype wire

// File: dv/tb.sv
`default_nettype none

// Self-checking bench for the bilinear texture sampler.
// Requests go in on the s_ stream (write texel or sample at u,v), filtered
// RGBA results come back on the m_ stream. A behavioral copy of the sampler
// lives here: each accepted request updates the local texel image or queues
// the pixel it must produce, and every returned pixel is checked against the
// oldest queued one, field by field.
// Rule kept throughout: a sample never touches a texel that has not been
// written. Before each sample the four texels of its footprint are written
// with random colors if they are still unknown.

module tb;
    import bts_pkg::*;

    localparam int          TEX_STRIDE   = MAX_WIDTH_DEF;
    localparam int          STORE_DEPTH  = MAX_WIDTH_DEF * MAX_HEIGHT_DEF;
    localparam int          HALF_I       = 1 << (FRAC_BITS_DEF - 1);
    localparam int          ONE_I        = 1 << FRAC_BITS_DEF;
    localparam longint unsigned ONE_FX   = 64'd1 << FRAC_BITS_DEF;
    localparam longint unsigned ROUND_FX = 64'd1 << (2 * FRAC_BITS_DEF - 1);
    localparam int          DRAIN_CYCLES = 16;
    localparam int          PHASE_REQS   = 150;

    typedef struct {
        bit        op;
        bit [7:0]  x;
        bit [7:0]  y;
        bit [31:0] rgba;
        bit [17:0] u;
        bit [17:0] v;
    } tex_req_t;

    typedef struct packed {
        bit [7:0] red;
        bit [7:0] green;
        bit [7:0] blue;
        bit [7:0] alpha;
        bit       outside;
    } pixel_t;

    // Sample footprint in texel space: the four corners and the weights
    typedef struct {
        bit              outside;
        int unsigned     u0, u1, v0, v1;
        longint unsigned s, t;
    } footprint_t;

    logic                  aclk = 1'b0;
    logic                  aresetn;
    logic                  cfg_we;
    logic [0:0]            cfg_addr;
    logic [SIZE_W-1:0]     cfg_wdata;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata;    // x, y, rgba, u, v, pad (low bit up)
    logic                  s_tuser;    // op
    logic                  m_tvalid;
    logic                  m_tready;
    logic [M_TDATA_W-1:0]  m_tdata;    // red, green, blue, alpha (low bit up)
    logic                  m_tuser;    // outside

    // Local copy of the sampler state
    bit [31:0]   texels      [STORE_DEPTH];
    bit          texel_known [STORE_DEPTH];
    int unsigned tex_w = MAX_WIDTH_DEF;
    int unsigned tex_h = MAX_HEIGHT_DEF;

    pixel_t      px_expected [$];
    pixel_t      want_px;
    int unsigned mismatches = 0;
    int unsigned req_count  = 0;
    bit          tx_calm    = 1'b0;   // no gaps on the request side
    bit          rx_calm    = 1'b0;   // no stalls on the result side

    bilinear_texture_sampler_unit u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // Mostly short gaps, now and then a long one
    function automatic int gap_len();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 45) return 0;
        if (pick < 85) return $urandom_range(1, 3);
        if (pick < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Map u,v into texel space: u' = u*(w-1) + 0.5, integer part picks the
    // corner, fraction is the weight. Second corner clamps at the last texel.
    function automatic footprint_t footprint(bit [17:0] cu, bit [17:0] cv);
        footprint_t f;
        longint     su, sv;
        su = longint'($signed(cu)) * longint'(tex_w - 1) + HALF_I;
        sv = longint'($signed(cv)) * longint'(tex_h - 1) + HALF_I;
        f = '{default: 0};
        f.outside = (su < 0) || (sv < 0) ||
                    (su >= longint'(tex_w) * ONE_I) || (sv >= longint'(tex_h) * ONE_I);
        if (!f.outside) begin
            f.u0 = int'(su >>> FRAC_BITS_DEF);
            f.v0 = int'(sv >>> FRAC_BITS_DEF);
            f.s  = longint'(su) & (ONE_FX - 1);
            f.t  = longint'(sv) & (ONE_FX - 1);
            f.u1 = (f.u0 + 1 < tex_w) ? f.u0 + 1 : tex_w - 1;
            f.v1 = (f.v0 + 1 < tex_h) ? f.v0 + 1 : tex_h - 1;
        end
        return f;
    endfunction

    // One channel: weighted sum of four corners, rounded half up
    function automatic bit [7:0] mix(bit [7:0] c00, bit [7:0] c10, bit [7:0] c01,
                                     bit [7:0] c11, longint unsigned s,
                                     longint unsigned t);
        longint unsigned acc;
        acc = longint'(c00) * (ONE_FX - s) * (ONE_FX - t)
            + longint'(c10) * s * (ONE_FX - t)
            + longint'(c01) * (ONE_FX - s) * t
            + longint'(c11) * s * t
            + ROUND_FX;
        return 8'(acc >> (2 * FRAC_BITS_DEF));
    endfunction

    function automatic pixel_t filter_at(bit [17:0] cu, bit [17:0] cv);
        footprint_t f;
        pixel_t     px;
        bit [31:0]  q00, q10, q01, q11;
        bit [7:0]   ch [4];
        f  = footprint(cu, cv);
        px = '0;
        if (f.outside) begin
            px.outside = 1'b1;
        end else begin
            q00 = texels[f.v0 * TEX_STRIDE + f.u0];
            q10 = texels[f.v0 * TEX_STRIDE + f.u1];
            q01 = texels[f.v1 * TEX_STRIDE + f.u0];
            q11 = texels[f.v1 * TEX_STRIDE + f.u1];
            // rgba packs R at the top byte down to A at the bottom
            for (int k = 0; k < 4; k++) begin
                ch[k] = mix(q00[24-8*k +: 8], q10[24-8*k +: 8],
                            q01[24-8*k +: 8], q11[24-8*k +: 8], f.s, f.t);
            end
            px.red   = ch[0];
            px.green = ch[1];
            px.blue  = ch[2];
            px.alpha = ch[3];
        end
        return px;
    endfunction

    // Drive one request, wait for the handshake, then update the local image
    // or queue the pixel it must produce.
    task automatic send_req(tex_req_t r);
        int gap;
        int addr;
        gap = tx_calm ? 0 : gap_len();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= r.op;
        s_tdata  <= {4'b0, r.v, r.u, r.rgba, r.y, r.x};
        do @(posedge aclk); while (!s_tready);
        req_count++;
        if (r.op == OP_WRITE) begin
            addr = int'(r.y) * TEX_STRIDE + int'(r.x);
            texels[addr]      = r.rgba;
            texel_known[addr] = 1'b1;
        end else begin
            px_expected.push_back(filter_at(r.u, r.v));
        end
    endtask

    // Write request; the coordinate fields are don't-care and get noise
    task automatic send_write(int unsigned col, int unsigned row, bit [31:0] rgba);
        tex_req_t r;
        r = '{op: OP_WRITE, x: 8'(col), y: 8'(row), rgba: rgba,
              u: 18'($urandom), v: 18'($urandom)};
        send_req(r);
    endtask

    task automatic fill_if_unknown(int unsigned col, int unsigned row);
        if (!texel_known[row * TEX_STRIDE + col]) begin
            send_write(col, row, $urandom);
        end
    endtask

    // Sample request; texel fields are ignored by the block, so they carry noise
    task automatic send_sample(bit [17:0] cu, bit [17:0] cv);
        footprint_t f;
        tex_req_t   r;
        f = footprint(cu, cv);
        if (!f.outside) begin
            fill_if_unknown(f.u0, f.v0);
            fill_if_unknown(f.u1, f.v0);
            fill_if_unknown(f.u0, f.v1);
            fill_if_unknown(f.u1, f.v1);
        end
        r = '{op: OP_SAMPLE, x: 8'($urandom), y: 8'($urandom), rgba: $urandom,
              u: cu, v: cv};
        send_req(r);
    endtask

    // Block goes idle: no request pending, all pixels back, pipeline empty
    task automatic settle();
        s_tvalid <= 1'b0;
        while (px_expected.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // Size register write; 0 reads back as 1, anything above the store clamps
    task automatic set_size(logic [0:0] idx, int unsigned raw);
        int unsigned val;
        settle();
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= SIZE_W'(raw);
        @(posedge aclk);
        cfg_we <= 1'b0;
        @(posedge aclk);
        val = raw & 32'h1FF;
        if (idx == REG_TEX_WIDTH) begin
            tex_w = (val == 0) ? 1 : (val > MAX_WIDTH_DEF) ? MAX_WIDTH_DEF : val;
        end else begin
            tex_h = (val == 0) ? 1 : (val > MAX_HEIGHT_DEF) ? MAX_HEIGHT_DEF : val;
        end
    endtask

    // Coordinate picker: inside [0,1], around the outside limits for the
    // current size, or anywhere in the 18-bit range
    function automatic bit [17:0] rand_coord(int unsigned size);
        int pick, lo, hi, sz;
        sz = int'(size);
        lo = 0;
        hi = ONE_I;
        if (sz > 1) begin
            lo = -(HALF_I / (sz - 1));
            hi = (sz * ONE_I - HALF_I) / (sz - 1);
        end
        pick = $urandom_range(0, 99);
        if (pick < 45) return 18'($urandom_range(0, ONE_I));
        if (pick < 65) begin
            return 18'(($urandom_range(0, 1) ? hi : lo) + int'($urandom_range(0, 8)) - 4);
        end
        return 18'($urandom);
    endfunction

    // Full-size texture out of reset: corner texels, in/out boundaries, and
    // the coordinate extremes
    task automatic test_reset_sizes();
        tx_calm = 1'b0;
        send_write(0, 0, 32'hFFFF_FFFF);
        send_write(1, 0, 32'h0000_0000);
        send_write(0, 1, 32'h1234_5678);
        send_write(1, 1, 32'h80FF_0180);
        send_write(255, 255, 32'hFFFF_FFFF);
        send_write(255, 0, 32'h0000_0000);
        send_sample(18'd0, 18'd0);                     // mid-texel, equal weights
        send_sample(-18'sd128, 18'd0);                 // just inside left edge
        send_sample(-18'sd129, 18'd0);                 // just outside left edge
        send_sample(18'd0, -18'sd129);                 // just outside top edge
        send_sample(18'd65664, 18'd65664);             // last texel, clamped corners
        send_sample(18'd65665, 18'd0);                 // just outside right edge
        send_sample(18'd0, 18'd65665);                 // just outside bottom edge
        send_sample(18'h1FFFF, 18'h1FFFF);             // most positive coords
        send_sample(18'h20000, 18'h20000);             // most negative coords
        send_sample(18'd65535, 18'd32768);
        send_sample(18'd256, 18'd256);
        send_write(255, 255, 32'h0000_0000);           // overwrite, then resample
        send_sample(18'd65664, 18'd65664);
    endtask

    // Register clamping: zero becomes one, values past the store size clamp
    task automatic test_size_clamping();
        set_size(REG_TEX_WIDTH, 0);
        set_size(REG_TEX_HEIGHT, 0);
        send_sample(18'h20000, 18'h1FFFF);   // 1x1: every coordinate maps inside
        send_sample(18'h1FFFF, 18'h20000);
        send_sample(18'd0, 18'd0);
        set_size(REG_TEX_WIDTH, 511);
        set_size(REG_TEX_HEIGHT, 257);
        send_sample(18'd65664, 18'd65664);
        send_sample(18'd65665, 18'd65664);
        set_size(REG_TEX_WIDTH, 2);
        set_size(REG_TEX_HEIGHT, 256);
        send_sample(18'd65536, 18'd0);
        send_sample(18'd98303, 18'd100);
        send_sample(18'd98304, 18'd100);
        send_write(200, 100, 32'hA5A5_5A5A);  // beyond current width, still kept
        set_size(REG_TEX_WIDTH, 256);
        send_sample(18'd51456, 18'd25760);
    endtask

    // Mixed traffic across several sizes, request gaps and result stalls
    task automatic test_random_traffic();
        int unsigned pw [8] = '{256, 1, 2, 3, 256, 1, 16, 0};
        int unsigned ph [8] = '{256, 1, 2, 7, 1, 256, 9, 511};
        int unsigned start;
        int          pick;
        for (int p = 0; p < 10; p++) begin
            set_size(REG_TEX_WIDTH, (p < 8) ? pw[p] : $urandom_range(0, 511));
            set_size(REG_TEX_HEIGHT, (p < 8) ? ph[p] : $urandom_range(0, 511));
            start = req_count;
            while (req_count - start < PHASE_REQS) begin
                if ($urandom_range(0, 63) == 0) tx_calm = !tx_calm;
                pick = $urandom_range(0, 99);
                if (pick < 20) begin
                    // mostly inside the texture in use, so samples hit them
                    send_write($urandom_range(0, tex_w - 1), $urandom_range(0, tex_h - 1),
                               $urandom);
                end else if (pick < 30) begin
                    send_write($urandom_range(0, 255), $urandom_range(0, 255), $urandom);
                end else begin
                    send_sample(rand_coord(tex_w), rand_coord(tex_h));
                end
            end
        end
        tx_calm = 1'b0;
    endtask

    function automatic void check_field(string name, int want, int got);
        if (want != got) begin
            $display("%0t: %s mismatch: expected %0d, got %0d", $time, name, want, got);
            mismatches++;
        end
    endfunction

    // Result side: compare every accepted pixel with the oldest expected one
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (px_expected.size() == 0) begin
                $display("%0t: result with none expected: expected nothing, got %h/%b",
                         $time, m_tdata, m_tuser);
                mismatches++;
            end else begin
                want_px = px_expected.pop_front();
                check_field("red",     want_px.red,     m_tdata[7:0]);
                check_field("green",   want_px.green,   m_tdata[15:8]);
                check_field("blue",    want_px.blue,    m_tdata[23:16]);
                check_field("alpha",   want_px.alpha,   m_tdata[31:24]);
                check_field("outside", want_px.outside, m_tuser);
            end
        end
    end

    // Result-side back-pressure, with calm stretches of steady ready
    initial begin : rx_stall
        int n;
        forever begin
            @(posedge aclk);
            if ($urandom_range(0, 127) == 0) rx_calm = !rx_calm;
            n = rx_calm ? 0 : gap_len();
            if (n > 0) begin
                m_tready <= 1'b0;
                repeat (n) @(posedge aclk);
            end
            m_tready <= 1'b1;
        end
    end

    initial begin
        aresetn   = 1'b0;
        cfg_we    = 1'b0;
        cfg_addr  = '0;
        cfg_wdata = '0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = 1'b0;
        m_tready  = 1'b0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_reset_sizes();
        test_size_clamping();
        test_random_traffic();

        settle();
        if (mismatches == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    // Watchdog well beyond the slowest legal run
    initial begin
        #20000000;
        $display("TEST FAILED");
        $finish;
    end

endmodule

`default_nettype wire
